// File: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions for the JSON string
// unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	typedef enum logic [3:0] {
		PH_QUOTE = 4'd0,
		PH_BODY  = 4'd1,
		PH_ESC   = 4'd2,
		PH_HEX1  = 4'd3,
		PH_BSL   = 4'd4,
		PH_U     = 4'd5,
		PH_HEX2  = 4'd6,
		PH_DONE  = 4'd7,
		PH_ERR   = 4'd8
	} phase_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CTRL_BS   = 8'h08;
	localparam logic [7:0] CTRL_FF   = 8'h0C;
	localparam logic [7:0] CTRL_LF   = 8'h0A;
	localparam logic [7:0] CTRL_CR   = 8'h0D;
	localparam logic [7:0] CTRL_TAB  = 8'h09;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	localparam logic [15:0] HI_SUR_MIN = 16'hD800;
	localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
	localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
	localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	localparam logic [20:0] UTF8_MAX1 = 21'h7F;
	localparam logic [20:0] UTF8_MAX2 = 21'h7FF;
	localparam logic [20:0] UTF8_MAX3 = 21'hFFFF;
	localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF8_LEAD4 = 8'hF0;
	localparam logic [7:0]  UTF8_CONT  = 8'h80;

	// Everything one accepted byte causes: up to four data bytes and an
	// optional end status.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      nbytes;
		logic            has_status;
		logic            status;
	} packet_t;

	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      nbytes;
	} utf8_t;

	typedef struct packed {
		logic       bad;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t r;
		r.bad = 1'b0;
		r.value = b[3:0];
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = b[3:0];
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r.value = b[3:0] + 4'd9;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= UTF8_MAX1) begin
			r.data[0] = cp[7:0];
			r.nbytes = 3'd1;
		end else if (cp <= UTF8_MAX2) begin
			r.data[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
			r.data[1] = UTF8_CONT | {2'b00, cp[5:0]};
			r.nbytes = 3'd2;
		end else if (cp <= UTF8_MAX3) begin
			r.data[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
			r.data[1] = UTF8_CONT | {2'b00, cp[11:6]};
			r.data[2] = UTF8_CONT | {2'b00, cp[5:0]};
			r.nbytes = 3'd3;
		end else begin
			r.data[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
			r.data[1] = UTF8_CONT | {2'b00, cp[17:12]};
			r.data[2] = UTF8_CONT | {2'b00, cp[11:6]};
			r.data[3] = UTF8_CONT | {2'b00, cp[5:0]};
			r.nbytes = 3'd4;
		end
		return r;
	endfunction

endpackage

// File: design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: takes one string byte per cycle unless stalled, runs the
// escape state machine and builds the packet of results that byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       in_byte,
	input  logic             last_byte,
	output logic             push,
	output jsu_pkg::packet_t push_pkt
);

	jsu_pkg::phase_t phase_q, phase_d;
	logic [15:0]     hex_accum_q, hex_accum_d;
	logic [1:0]      hex_count_q, hex_count_d;
	logic [9:0]      high_half_q, high_half_d;

	jsu_pkg::hex_t   hv;
	jsu_pkg::utf8_t  utf;
	logic [15:0]     acc_new;
	logic [20:0]     cp_pair;
	logic            quad_done;
	logic            accept;

	assign accept = in_valid && !in_stall;

	// Next state of the parser.
	always_comb begin
		phase_d     = phase_q;
		hex_accum_d = hex_accum_q;
		hex_count_d = hex_count_q;
		high_half_d = high_half_q;
		hv          = jsu_pkg::hex_decode(in_byte);
		acc_new     = {hex_accum_q[11:0], hv.value};
		quad_done   = (hex_count_q == 2'd3);
		unique case (phase_q)
			jsu_pkg::PH_QUOTE: begin
				phase_d = (in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY : jsu_pkg::PH_ERR;
			end
			jsu_pkg::PH_BODY: begin
				if (in_byte == jsu_pkg::CH_QUOTE) begin
					phase_d = jsu_pkg::PH_DONE;
				end else if (in_byte == jsu_pkg::CH_BSL) begin
					phase_d = jsu_pkg::PH_ESC;
				end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
					phase_d = jsu_pkg::PH_ERR;
				end
			end
			jsu_pkg::PH_ESC: begin
				case (in_byte)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH,
					jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
					jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T: phase_d = jsu_pkg::PH_BODY;
					jsu_pkg::CH_LOW_U: begin
						phase_d     = jsu_pkg::PH_HEX1;
						hex_accum_d = '0;
						hex_count_d = '0;
					end
					default: phase_d = jsu_pkg::PH_ERR;
				endcase
			end
			jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
				if (hv.bad) begin
					phase_d = jsu_pkg::PH_ERR;
				end else begin
					hex_accum_d = acc_new;
					if (!quad_done) begin
						hex_count_d = hex_count_q + 2'd1;
					end else begin
						hex_count_d = '0;
						if (phase_q == jsu_pkg::PH_HEX2) begin
							if (acc_new >= jsu_pkg::LO_SUR_MIN && acc_new <= jsu_pkg::LO_SUR_MAX) begin
								phase_d = jsu_pkg::PH_BODY;
							end else begin
								phase_d = jsu_pkg::PH_ERR;
							end
						end else if (acc_new >= jsu_pkg::HI_SUR_MIN &&
						             acc_new <= jsu_pkg::HI_SUR_MAX) begin
							// The surrogate base has zero low bits, so the offset is a slice.
							high_half_d = acc_new[9:0];
							phase_d     = jsu_pkg::PH_BSL;
						end else if (acc_new >= jsu_pkg::LO_SUR_MIN &&
						             acc_new <= jsu_pkg::LO_SUR_MAX) begin
							phase_d = jsu_pkg::PH_ERR;
						end else begin
							phase_d = jsu_pkg::PH_BODY;
						end
					end
				end
			end
			jsu_pkg::PH_BSL: begin
				phase_d = (in_byte == jsu_pkg::CH_BSL) ? jsu_pkg::PH_U : jsu_pkg::PH_ERR;
			end
			jsu_pkg::PH_U: begin
				if (in_byte == jsu_pkg::CH_LOW_U) begin
					phase_d     = jsu_pkg::PH_HEX2;
					hex_accum_d = '0;
					hex_count_d = '0;
				end else begin
					phase_d = jsu_pkg::PH_ERR;
				end
			end
			default: phase_d = jsu_pkg::PH_ERR;
		endcase
	end

	// Results of the byte.
	always_comb begin
		push_pkt = '0;
		cp_pair  = jsu_pkg::SUPP_BASE + {1'b0, high_half_q, acc_new[9:0]};
		utf      = '0;
		unique case (phase_q)
			jsu_pkg::PH_BODY: begin
				if (in_byte != jsu_pkg::CH_QUOTE && in_byte != jsu_pkg::CH_BSL &&
				    in_byte >= jsu_pkg::CTRL_LIMIT) begin
					utf.data[0] = in_byte;
					utf.nbytes  = 3'd1;
				end
			end
			jsu_pkg::PH_ESC: begin
				utf.nbytes = 3'd1;
				case (in_byte)
					jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL,
					jsu_pkg::CH_SLASH: utf.data[0] = in_byte;
					jsu_pkg::CH_LOW_B: utf.data[0] = jsu_pkg::CTRL_BS;
					jsu_pkg::CH_LOW_F: utf.data[0] = jsu_pkg::CTRL_FF;
					jsu_pkg::CH_LOW_N: utf.data[0] = jsu_pkg::CTRL_LF;
					jsu_pkg::CH_LOW_R: utf.data[0] = jsu_pkg::CTRL_CR;
					jsu_pkg::CH_LOW_T: utf.data[0] = jsu_pkg::CTRL_TAB;
					default: utf.nbytes = 3'd0;
				endcase
			end
			jsu_pkg::PH_HEX1: begin
				if (!hv.bad && quad_done &&
				    !(acc_new >= jsu_pkg::HI_SUR_MIN && acc_new <= jsu_pkg::LO_SUR_MAX)) begin
					utf = jsu_pkg::utf8_encode({5'b00000, acc_new});
				end
			end
			jsu_pkg::PH_HEX2: begin
				if (!hv.bad && quad_done &&
				    acc_new >= jsu_pkg::LO_SUR_MIN && acc_new <= jsu_pkg::LO_SUR_MAX) begin
					utf = jsu_pkg::utf8_encode(cp_pair);
				end
			end
			default: utf = '0;
		endcase
		push_pkt.data       = utf.data;
		push_pkt.nbytes     = utf.nbytes;
		push_pkt.has_status = last_byte;
		push_pkt.status     = (phase_d != jsu_pkg::PH_DONE);
	end

	assign push = accept && (push_pkt.nbytes != 3'd0 || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= jsu_pkg::PH_QUOTE;
			hex_accum_q <= '0;
			hex_count_q <= '0;
			high_half_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				// The final byte closes the string; the next one starts fresh.
				phase_q     <= jsu_pkg::PH_QUOTE;
				hex_accum_q <= '0;
				hex_count_q <= '0;
				high_half_q <= '0;
			end else begin
				phase_q     <= phase_d;
				hex_accum_q <= hex_accum_d;
				hex_count_q <= hex_count_d;
				high_half_q <= high_half_d;
			end
		end
	end

endmodule

// File: design/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small first-in first-out queue of result packets between the parser and
// the output serializer.
// ----------------------------------------------------------------------------
module jsu_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::packet_t push_pkt,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output jsu_pkg::packet_t head_pkt
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	jsu_pkg::packet_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign head_pkt = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: walks the packet at the head of the queue and presents
// its data bytes and end status one transfer at a time.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  jsu_pkg::packet_t head_pkt,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       data_byte,
	output logic             is_status,
	output logic             status,
	output logic             run_end
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_data;
	logic       transfer;

	assign total     = head_pkt.nbytes + {2'b00, head_pkt.has_status};
	assign is_data   = (idx_q < head_pkt.nbytes);
	assign out_valid = !empty;
	assign data_byte = is_data ? head_pkt.data[idx_q[1:0]] : 8'h00;
	assign is_status = !is_data;
	assign status    = is_data ? 1'b0 : head_pkt.status;
	assign run_end   = (idx_q == total - 3'd1);
	assign transfer  = out_valid && !out_stall;
	assign pop       = transfer && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (transfer) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	// Every queued packet carries at least one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (total != 3'd0))
		else $error("queued packet with no results");

	// The walk never runs past the end of the packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < total))
		else $error("result index beyond packet");

	// A finished packet leaves the walk at its start.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 3'd0))
		else $error("result index not cleared after packet");

	// A status result is always the last one of its packet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_status) |-> run_end)
		else $error("status result not last in packet");

endmodule

// File: design/json_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// Decodes a quoted JSON string literal, one byte per transfer, into UTF-8
// data bytes followed by an end status.
// ----------------------------------------------------------------------------
// The input side takes one byte per cycle as long as the result queue
// (QUEUE_DEPTH packets) has room; the parser decides in that cycle what the
// byte yields and writes any results as one packet. The output side sends one
// result per cycle unless out_stall holds it. Results per byte: none for
// quotes, backslashes and the first three hex digits of an escape, one for a
// plain byte or escape letter, up to four for the digit that completes a \u
// escape, plus one for the status on the final byte. Results are held in
// the queue; an output stall only holds the input once the queue has filled.
module json_string_unescaper_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       is_status,
	output logic       status,
	output logic       run_end
);

	jsu_pkg::packet_t push_pkt;
	jsu_pkg::packet_t head_pkt;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;

	assign in_stall = full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.push      (push),
		.push_pkt  (push_pkt)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_pkt (push_pkt),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head_pkt (head_pkt)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_pkt  (head_pkt),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.is_status (is_status),
		.status    (status),
		.run_end   (run_end)
	);

endmodule
